/* rtl/nfsa_pkg.sv */
// shared constants for the next-fit slot allocator with handle maps
// kind codes, status codes and default sizes; no dependencies
package nfsa_pkg;

   // default pool and map sizes
   localparam int SLOT_COUNT_DEF     = 2048;
   localparam int CLIENT_HANDLES_DEF = 1152;
   localparam int SERVER_HANDLES_DEF = 1024;

   // fixed field widths of the request and response beats
   localparam int KIND_W   = 3;
   localparam int HANDLE_W = 11;
   localparam int STATUS_W = 2;

   // used bitmap is stored as words of this many slots
   localparam int WORD_W = 64;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC_CLIENT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC_SERVER  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE_CLIENT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FREE_SERVER   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOOKUP_CLIENT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOOKUP_SERVER = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

endpackage

/* rtl/nfsa_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module nfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/next_fit_slot_allocator_handle_maps.sv */
// top level of the next-fit slot allocator with client and server handle maps
// depends on nfsa_pkg and nfsa_ram
//
// Usage
//   A request beat (req_kind, req_handle) is taken at a rising edge with start
//   high and busy low. Each request gives exactly one response beat, shown on
//   rsp_slot, rsp_status and rsp_free_slots for one cycle with rsp_strobe high.
//   The receiver cannot stall; the response registers hold the beat for that
//   single cycle and a new request may be taken in the strobe cycle.
// Sequence
//   unknown kind or handle out of range: strobe in the cycle after the request
//   lookup: S_MAP; free: S_MAP, then S_FREE unless the handle is empty
//   alloc: S_SCAN over the NW = SLOT_COUNT/64 bitmap words (32 by default),
//   one word read per cycle through the bitmap ram read port
//   busy stays high until the response is registered
// Reset
//   synchronous reset starts a clearing pass that writes zero into the bitmap
//   and both map rams, one address per cycle, covering max(CLIENT_HANDLES,
//   SERVER_HANDLES, NW) addresses (1152 by default); busy is high meanwhile
module next_fit_slot_allocator_handle_maps #(
   parameter int SLOT_COUNT     = nfsa_pkg::SLOT_COUNT_DEF,
   parameter int CLIENT_HANDLES = nfsa_pkg::CLIENT_HANDLES_DEF,
   parameter int SERVER_HANDLES = nfsa_pkg::SERVER_HANDLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [nfsa_pkg::KIND_W-1:0]     req_kind,
   input  logic [nfsa_pkg::HANDLE_W-1:0]   req_handle,
   output logic                            rsp_strobe,
   output logic [$clog2(SLOT_COUNT)-1:0]   rsp_slot,
   output logic [nfsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [$clog2(SLOT_COUNT)-1:0]   rsp_free_slots
);

   import nfsa_pkg::*;

   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NW        = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int WA_W      = (NW > 1) ? $clog2(NW) : 1;
   localparam int PASS_W    = $clog2(NW + 1);
   localparam int CA_W      = (CLIENT_HANDLES > 1) ? $clog2(CLIENT_HANDLES) : 1;
   localparam int SA_W      = (SERVER_HANDLES > 1) ? $clog2(SERVER_HANDLES) : 1;
   localparam int MAP_MAX   = (CLIENT_HANDLES > SERVER_HANDLES) ? CLIENT_HANDLES
                                                                : SERVER_HANDLES;
   localparam int CLR_DEPTH = (MAP_MAX > NW) ? MAP_MAX : NW;
   localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
   localparam int TAIL_BITS = SLOT_COUNT - (NW - 1) * WORD_W;
   localparam int FREE_MAX  = SLOT_COUNT - 1;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MAP   = 3'd3;
   localparam logic [2:0] S_FREE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                client_ff, client_in;
   logic [WA_W-1:0]     cur_word_ff, cur_word_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic [BIT_W-1:0]    start_bit_ff, start_bit_in;
   logic [SLOT_W-1:0]   free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]   last_given_ff, last_given_in;
   logic [SLOT_W-1:0]   free_total_ff, free_total_in;
   logic [CLR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // ram ports
   logic              bm_wr_en, bm_rd_en;
   logic [WA_W-1:0]   bm_wr_addr, bm_rd_addr;
   logic [WORD_W-1:0] bm_wr_data, bm_rd_data;
   logic              cm_wr_en, cm_rd_en;
   logic [CA_W-1:0]   cm_wr_addr, cm_rd_addr;
   logic [SLOT_W-1:0] cm_wr_data, cm_rd_data;
   logic              sm_wr_en, sm_rd_en;
   logic [SA_W-1:0]   sm_wr_addr, sm_rd_addr;
   logic [SLOT_W-1:0] sm_wr_data, sm_rd_data;

   // decode and address helpers
   logic              req_client, req_known, req_in_range, req_alloc;
   logic [31:0]       req_h32, hold_h32, next32, clr32, found32, fslot32;
   logic [31:0]       start_word32, fword32;
   logic [CA_W-1:0]   hold_caddr;
   logic [SA_W-1:0]   hold_saddr;
   logic [SLOT_W-1:0] map_rd;
   logic              hold_alloc, hold_lookup;

   // scan unit
   logic [WORD_W-1:0] ge_mask, range_mask, avail, found_onehot, fbit_onehot;
   logic              found_any;
   logic [BIT_W-1:0]  found_bit;
   logic [SLOT_W-1:0] found_slot, dec_total;
   logic              scan_first, scan_final;

   nfsa_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   nfsa_ram #(.WIDTH(SLOT_W), .DEPTH(CLIENT_HANDLES)) u_client_map (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (cm_wr_addr),
      .wr_data (cm_wr_data),
      .rd_en   (cm_rd_en),
      .rd_addr (cm_rd_addr),
      .rd_data (cm_rd_data)
   );

   nfsa_ram #(.WIDTH(SLOT_W), .DEPTH(SERVER_HANDLES)) u_server_map (
      .clock   (clock),
      .wr_en   (sm_wr_en),
      .wr_addr (sm_wr_addr),
      .wr_data (sm_wr_data),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_rd_addr),
      .rd_data (sm_rd_data)
   );

   // request decode
   always_comb begin
      req_client = (req_kind == KIND_ALLOC_CLIENT) || (req_kind == KIND_FREE_CLIENT)
                   || (req_kind == KIND_LOOKUP_CLIENT);
      req_known  = req_client || (req_kind == KIND_ALLOC_SERVER)
                   || (req_kind == KIND_FREE_SERVER) || (req_kind == KIND_LOOKUP_SERVER);
      req_alloc  = (req_kind == KIND_ALLOC_CLIENT) || (req_kind == KIND_ALLOC_SERVER);
      req_h32    = 32'(req_handle);
      req_in_range = req_client ? (req_h32 < 32'(CLIENT_HANDLES))
                                : (req_h32 < 32'(SERVER_HANDLES));
      hold_h32   = 32'(handle_ff);
      hold_caddr = hold_h32[CA_W-1:0];
      hold_saddr = hold_h32[SA_W-1:0];
      hold_alloc  = (kind_ff == KIND_ALLOC_CLIENT) || (kind_ff == KIND_ALLOC_SERVER);
      hold_lookup = (kind_ff == KIND_LOOKUP_CLIENT) || (kind_ff == KIND_LOOKUP_SERVER);
      map_rd     = client_ff ? cm_rd_data : sm_rd_data;
      // scan starts one past the last slot given, wrapping to slot 0
      next32 = 32'(last_given_ff) + 32'd1;
      if (next32 == 32'(SLOT_COUNT)) begin
         next32 = 32'd0;
      end
      start_word32 = next32 >> BIT_W;
      clr32   = 32'(clr_cnt_ff);
      fslot32 = 32'(free_slot_ff);
      fword32 = fslot32 >> BIT_W;
      fbit_onehot = WORD_W'(1) << fslot32[BIT_W-1:0];
   end

   // one bitmap word a cycle: mask out slot 0, slots past the pool and the
   // part of the start word that belongs to the other end of the circle
   always_comb begin
      scan_first = (pass_ff == '0);
      scan_final = (pass_ff == PASS_W'(NW));
      for (int b = 0; b < WORD_W; b++) begin
         ge_mask[b]    = (32'(b) >= 32'(start_bit_ff));
         range_mask[b] = (cur_word_ff != WA_W'(NW - 1)) || (b < TAIL_BITS);
      end
      if (cur_word_ff == '0) begin
         range_mask[0] = 1'b0;
      end
      avail = ~bm_rd_data & range_mask;
      if (scan_first) begin
         avail = avail & ge_mask;
      end
      if (scan_final) begin
         avail = avail & ~ge_mask;
      end
      found_any = |avail;
      found_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            found_bit = BIT_W'(b);
         end
      end
      found32      = 32'({cur_word_ff, found_bit});
      found_slot   = found32[SLOT_W-1:0];
      found_onehot = WORD_W'(1) << found_bit;
      dec_total    = (free_total_ff != '0) ? (free_total_ff - SLOT_W'(1)) : free_total_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      handle_in     = handle_ff;
      client_in     = client_ff;
      cur_word_in   = cur_word_ff;
      pass_in       = pass_ff;
      start_bit_in  = start_bit_ff;
      free_slot_in  = free_slot_ff;
      last_given_in = last_given_ff;
      free_total_in = free_total_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      bm_wr_en   = 1'b0;
      bm_wr_addr = cur_word_ff;
      bm_wr_data = bm_rd_data;
      bm_rd_en   = 1'b0;
      bm_rd_addr = cur_word_ff;
      cm_wr_en   = 1'b0;
      cm_wr_addr = hold_caddr;
      cm_wr_data = '0;
      cm_rd_en   = 1'b0;
      cm_rd_addr = req_h32[CA_W-1:0];
      sm_wr_en   = 1'b0;
      sm_wr_addr = hold_saddr;
      sm_wr_data = '0;
      sm_rd_en   = 1'b0;
      sm_rd_addr = req_h32[SA_W-1:0];

      case (state_ff)
         // zero every ram, one address a cycle
         S_CLEAR: begin
            bm_wr_en   = (clr32 < 32'(NW));
            bm_wr_addr = clr32[WA_W-1:0];
            bm_wr_data = '0;
            cm_wr_en   = (clr32 < 32'(CLIENT_HANDLES));
            cm_wr_addr = clr32[CA_W-1:0];
            sm_wr_en   = (clr32 < 32'(SERVER_HANDLES));
            sm_wr_addr = clr32[SA_W-1:0];
            clr_cnt_in = clr_cnt_ff + CLR_W'(1);
            if (clr32 == 32'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take a request beat
         S_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               handle_in = req_handle;
               client_in = req_client;
               if (!req_known) begin
                  rsp_strobe_in = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = STATUS_OK;
               end else if (!req_in_range) begin
                  rsp_strobe_in = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = STATUS_EMPTY;
               end else if (req_alloc) begin
                  cur_word_in  = start_word32[WA_W-1:0];
                  start_bit_in = next32[BIT_W-1:0];
                  pass_in      = '0;
                  bm_rd_en     = 1'b1;
                  bm_rd_addr   = start_word32[WA_W-1:0];
                  state_in     = S_SCAN;
               end else begin
                  cm_rd_en = req_client;
                  sm_rd_en = !req_client;
                  state_in = S_MAP;
               end
            end
         end
         // next-fit scan, one word per cycle
         S_SCAN: begin
            if (found_any) begin
               bm_wr_en      = 1'b1;
               bm_wr_data    = bm_rd_data | found_onehot;
               last_given_in = found_slot;
               free_total_in = dec_total;
               cm_wr_en      = client_ff;
               sm_wr_en      = !client_ff;
               cm_wr_data    = found_slot;
               sm_wr_data    = found_slot;
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = found_slot;
               rsp_status_in = (dec_total == '0) ? STATUS_EXHAUSTED : STATUS_OK;
               state_in      = S_IDLE;
            end else if (scan_final) begin
               // pool full: the handle is mapped to none
               cm_wr_en      = client_ff;
               sm_wr_en      = !client_ff;
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = STATUS_NO_SLOT;
               state_in      = S_IDLE;
            end else begin
               cur_word_in = (cur_word_ff == WA_W'(NW - 1)) ? '0
                                                            : cur_word_ff + WA_W'(1);
               pass_in     = pass_ff + PASS_W'(1);
               bm_rd_en    = 1'b1;
               bm_rd_addr  = cur_word_in;
            end
         end
         // map entry is back: an empty entry or a lookup answers, free goes on to the bitmap
         S_MAP: begin
            free_slot_in = map_rd;
            if (map_rd == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = STATUS_EMPTY;
               state_in      = S_IDLE;
            end else if (hold_lookup || hold_alloc) begin
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = map_rd;
               rsp_status_in = STATUS_OK;
               state_in      = S_IDLE;
            end else begin
               cm_wr_en   = client_ff;
               sm_wr_en   = !client_ff;
               bm_rd_en   = 1'b1;
               bm_rd_addr = fslot32 >= 32'(SLOT_COUNT) ? '0 : (32'(map_rd) >> BIT_W)
                            >= 32'(NW) ? '0 : WA_W'(32'(map_rd) >> BIT_W);
               state_in   = S_FREE;
            end
         end
         // clear the used bit if it is set
         S_FREE: begin
            if ((bm_rd_data & fbit_onehot) != '0) begin
               bm_wr_en   = 1'b1;
               bm_wr_addr = fword32[WA_W-1:0];
               bm_wr_data = bm_rd_data & ~fbit_onehot;
               if (32'(free_total_ff) < 32'(FREE_MAX)) begin
                  free_total_in = free_total_ff + SLOT_W'(1);
               end
            end
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = free_slot_ff;
            rsp_status_in = STATUS_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         last_given_ff <= SLOT_W'(1);
         free_total_ff <= SLOT_W'(FREE_MAX);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         last_given_ff <= last_given_in;
         free_total_ff <= free_total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      handle_ff     <= handle_in;
      client_ff     <= client_in;
      cur_word_ff   <= cur_word_in;
      pass_ff       <= pass_in;
      start_bit_ff  <= start_bit_in;
      free_slot_ff  <= free_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_slots = free_total_ff;

endmodule

/* verif/tb.sv */
// testbench for next_fit_slot_allocator_handle_maps: directed beats, a pool exhaustion pass
// and random traffic, each response checked against an in-bench model of the slot pool
// depends on nfsa_pkg and the rtl of the allocator
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nfsa_pkg::*;

   localparam int SLOT_W       = $clog2(SLOT_COUNT_DEF);
   localparam int LAST_SLOT    = SLOT_COUNT_DEF - 1;
   localparam int HANDLE_MAX   = (1 << HANDLE_W) - 1;
   localparam int ALL_HANDLES  = CLIENT_HANDLES_DEF + SERVER_HANDLES_DEF;
   localparam int IDLE_PCT     = 7;
   localparam int WATCHDOG_MAX = 5000;
   localparam int TAIL_CYCLES  = 64;
   localparam int RANDOM_BEATS = 100;
   localparam int FREE_STRIDE  = 32;

   // kind codes the block does not decode
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   free_slots;
   } slot_beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [HANDLE_W-1:0]   req_handle = '0;
   logic                  rsp_strobe;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_free_slots;

   // model of the pool and both handle maps
   bit                    pool_used [SLOT_COUNT_DEF];
   int                    pool_free;
   int                    pool_last;
   logic [SLOT_W-1:0]     client_slot [CLIENT_HANDLES_DEF];
   logic [SLOT_W-1:0]     server_slot [SERVER_HANDLES_DEF];

   slot_beat_type         expected_beats [$];
   slot_beat_type         due_beat;
   bit                    steady_sender = 1'b0;
   int                    quiet_cycles = 0;
   int                    n_errors = 0;
   int                    n_requests = 0;
   int                    n_checked = 0;
   int                    n_exhausted = 0;
   int                    n_refused = 0;

   next_fit_slot_allocator_handle_maps i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_handle     (req_handle),
      .rsp_strobe     (rsp_strobe),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status),
      .rsp_free_slots (rsp_free_slots)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_pool_model();
      foreach (pool_used[i]) pool_used[i] = 1'b0;
      foreach (client_slot[i]) client_slot[i] = '0;
      foreach (server_slot[i]) server_slot[i] = '0;
      pool_free = LAST_SLOT;
      pool_last = 1;
   endfunction

   // next-fit search from the slot after the last one given, wrapping round to slot 1
   function automatic logic [SLOT_W-1:0] claim_next_slot();
      int found;
      found = 0;
      for (int i = pool_last + 1; i < SLOT_COUNT_DEF && found == 0; i++)
         if (!pool_used[i]) found = i;
      for (int i = 1; i <= pool_last && found == 0; i++)
         if (!pool_used[i]) found = i;
      if (found != 0) begin
         pool_last = found;
         pool_used[found] = 1'b1;
         if (pool_free > 0) pool_free--;
      end
      return SLOT_W'(found);
   endfunction

   // updates the model for one request beat and gives the response it should cause
   function automatic slot_beat_type apply_request(input logic [KIND_W-1:0] kind,
                                                   input logic [HANDLE_W-1:0] handle);
      slot_beat_type     beat;
      logic              to_client;
      logic              mapped;
      logic [SLOT_W-1:0] held;
      beat = '0;
      held = '0;
      to_client = (kind[0] == 1'b0);
      mapped = to_client ? (handle < CLIENT_HANDLES_DEF) : (handle < SERVER_HANDLES_DEF);
      if (mapped) held = to_client ? client_slot[handle] : server_slot[handle];
      if (kind > KIND_LOOKUP_SERVER) begin
         beat.status = STATUS_OK;
      end else if (!mapped) begin
         beat.status = STATUS_EMPTY;
      end else begin
         case (kind)
            KIND_ALLOC_CLIENT, KIND_ALLOC_SERVER: begin
               // an allocation over a mapped handle leaks the old slot
               beat.slot = claim_next_slot();
               if (to_client) client_slot[handle] = beat.slot;
               else server_slot[handle] = beat.slot;
               if (beat.slot == '0) beat.status = STATUS_NO_SLOT;
               else if (pool_free == 0) beat.status = STATUS_EXHAUSTED;
            end
            KIND_FREE_CLIENT, KIND_FREE_SERVER: begin
               beat.slot = held;
               if (held == '0) begin
                  beat.status = STATUS_EMPTY;
               end else begin
                  if (to_client) client_slot[handle] = '0;
                  else server_slot[handle] = '0;
                  if (pool_used[held]) begin
                     pool_used[held] = 1'b0;
                     if (pool_free < LAST_SLOT) pool_free++;
                  end
               end
            end
            default: begin
               beat.slot = held;
               if (held == '0) beat.status = STATUS_EMPTY;
            end
         endcase
      end
      beat.free_slots = SLOT_W'(pool_free);
      return beat;
   endfunction

   // handles mostly from a small set at each end of the map, sometimes anywhere
   function automatic logic [HANDLE_W-1:0] pick_handle(input logic to_server);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return HANDLE_W'($urandom_range(0, HANDLE_MAX));
      if (roll < 56) return HANDLE_W'($urandom_range(0, 47));
      if (to_server) return HANDLE_W'($urandom_range(SERVER_HANDLES_DEF - 48,
                                                      SERVER_HANDLES_DEF - 1));
      return HANDLE_W'($urandom_range(CLIENT_HANDLES_DEF - 48, CLIENT_HANDLES_DEF - 1));
   endfunction

   // present one request beat and wait until it is taken; start stays high afterwards
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [HANDLE_W-1:0] handle);
      slot_beat_type beat;
      int            gap;
      if (!steady_sender && $urandom_range(0, 99) < IDLE_PCT) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_kind   <= kind;
      req_handle <= handle;
      do @(posedge clock); while (busy !== 1'b0);
      beat = apply_request(kind, handle);
      expected_beats.push_back(beat);
      n_requests++;
      if (beat.status == STATUS_EXHAUSTED && kind <= KIND_ALLOC_SERVER) n_exhausted++;
      if (beat.status == STATUS_NO_SLOT) n_refused++;
   endtask

   // drop start and hold off until every outstanding response has come back
   task automatic settle_responses();
      start <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   // extremes of the handles, every kind, empty handles and out-of-range handles
   task automatic test_directed_ops();
      send_request(KIND_LOOKUP_CLIENT, 11'd0);
      send_request(KIND_FREE_SERVER, 11'd0);
      send_request(KIND_ALLOC_CLIENT, 11'd0);
      send_request(KIND_ALLOC_SERVER, SERVER_HANDLES_DEF - 1);
      send_request(KIND_ALLOC_CLIENT, CLIENT_HANDLES_DEF - 1);
      send_request(KIND_LOOKUP_CLIENT, 11'd0);
      send_request(KIND_LOOKUP_SERVER, SERVER_HANDLES_DEF - 1);
      send_request(KIND_LOOKUP_CLIENT, CLIENT_HANDLES_DEF - 1);
      send_request(KIND_FREE_CLIENT, 11'd0);
      send_request(KIND_FREE_CLIENT, 11'd0);
      send_request(KIND_LOOKUP_CLIENT, 11'd0);
      send_request(KIND_ALLOC_CLIENT, CLIENT_HANDLES_DEF - 1);
      // handles past the end of their map
      send_request(KIND_ALLOC_SERVER, SERVER_HANDLES_DEF);
      send_request(KIND_FREE_SERVER, HANDLE_MAX);
      send_request(KIND_LOOKUP_SERVER, 11'd1500);
      send_request(KIND_ALLOC_CLIENT, CLIENT_HANDLES_DEF);
      send_request(KIND_FREE_CLIENT, HANDLE_MAX);
      send_request(KIND_LOOKUP_CLIENT, CLIENT_HANDLES_DEF);
      // undecoded kinds
      send_request(KIND_SPARE_A, 11'd0);
      send_request(KIND_SPARE_B, HANDLE_MAX);
      send_request(KIND_FREE_SERVER, SERVER_HANDLES_DEF - 1);
      send_request(KIND_FREE_CLIENT, CLIENT_HANDLES_DEF - 1);
      send_request(KIND_LOOKUP_SERVER, SERVER_HANDLES_DEF - 1);
      send_request(KIND_ALLOC_SERVER, 11'd0);
   endtask

   // mixed allocs, frees and lookups with some noise
   task automatic test_random_traffic(input int count);
      int                roll;
      logic              side;
      logic [KIND_W-1:0] kind;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         side = 1'($urandom_range(0, 1));
         if (roll < 6) kind = side ? KIND_SPARE_B : KIND_SPARE_A;
         else if (roll < 42) kind = side ? KIND_ALLOC_SERVER : KIND_ALLOC_CLIENT;
         else if (roll < 72) kind = side ? KIND_FREE_SERVER : KIND_FREE_CLIENT;
         else kind = side ? KIND_LOOKUP_SERVER : KIND_LOOKUP_CLIENT;
         send_request(kind, pick_handle(side));
      end
   endtask

   // fill the pool back to back, hit the full pool, then release a spread of handles
   task automatic test_pool_exhaustion();
      int cursor;
      cursor = 0;
      steady_sender = 1'b1;
      while (pool_free != 0) begin
         if (cursor < CLIENT_HANDLES_DEF)
            send_request(KIND_ALLOC_CLIENT, HANDLE_W'(cursor));
         else
            send_request(KIND_ALLOC_SERVER, HANDLE_W'(cursor - CLIENT_HANDLES_DEF));
         cursor = (cursor + 1) % ALL_HANDLES;
      end
      // pool full: the handle is mapped to none
      send_request(KIND_ALLOC_SERVER, 11'd7);
      send_request(KIND_ALLOC_CLIENT, CLIENT_HANDLES_DEF - 1);
      send_request(KIND_LOOKUP_SERVER, 11'd7);
      send_request(KIND_FREE_CLIENT, CLIENT_HANDLES_DEF - 1);
      steady_sender = 1'b0;
      for (int h = 0; h < CLIENT_HANDLES_DEF; h += FREE_STRIDE)
         if (client_slot[h] != '0) send_request(KIND_FREE_CLIENT, HANDLE_W'(h));
      for (int h = 0; h < SERVER_HANDLES_DEF; h += FREE_STRIDE)
         if (server_slot[h] != '0) send_request(KIND_FREE_SERVER, HANDLE_W'(h));
   endtask

   // response checker: every strobed beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_beats.size() == 0) begin
            $error("response beat with nothing expected: slot %0d status %0d free %0d",
                   rsp_slot, rsp_status, rsp_free_slots);
            n_errors++;
         end else begin
            due_beat = expected_beats.pop_front();
            n_checked++;
            if (rsp_slot !== due_beat.slot) begin
               $error("slot: expected %0d, got %0d", due_beat.slot, rsp_slot);
               n_errors++;
            end
            if (rsp_status !== due_beat.status) begin
               $error("status: expected %0d, got %0d", due_beat.status, rsp_status);
               n_errors++;
            end
            if (rsp_free_slots !== due_beat.free_slots) begin
               $error("free_slots: expected %0d, got %0d", due_beat.free_slots,
                      rsp_free_slots);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with neither a request nor a response beat
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("timeout: no beat for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset_pool_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      settle_responses();
      test_random_traffic(RANDOM_BEATS);
      settle_responses();
      test_pool_exhaustion();
      settle_responses();
      test_random_traffic(RANDOM_BEATS);
      settle_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d response beats never arrived", expected_beats.size());
         n_errors++;
      end
      $display("run covered %0d request beats and %0d checked responses", n_requests,
               n_checked);
      $display("pool ran dry %0d times and %0d allocations were refused", n_exhausted,
               n_refused);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/nfsa_pkg.sv
rtl/nfsa_ram.sv
rtl/next_fit_slot_allocator_handle_maps.sv
verif/tb.sv
